FILE: hw/rtl/hbs_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants for the heightmap bilinear sampler.
// Used by every module of the block except hbs_ram; depends on nothing else.
package hbs_pkg;

	// Field widths fixed by the transaction formats.
	localparam int DIM_W    = 9;
	localparam int CFG_W    = 24;
	localparam int CIDX_W   = 3;
	localparam int HGT_W    = 16;
	localparam int FRAC_W   = 16;
	localparam int COORD_W  = 32;
	localparam int OUT_W    = 32;
	// Width of corner address arithmetic before it wraps to the memory size.
	localparam int SUM_W    = 20;

	// Request types.
	localparam logic REQ_LOAD  = 1'b0;
	localparam logic REQ_QUERY = 1'b1;

	// Configuration register indexes.
	localparam logic [CIDX_W-1:0] REG_GRID_WIDTH      = 3'd0;
	localparam logic [CIDX_W-1:0] REG_GRID_HEIGHT     = 3'd1;
	localparam logic [CIDX_W-1:0] REG_CELL_SIZE_RECIP = 3'd2;
	localparam logic [CIDX_W-1:0] REG_VERTICAL_SCALE  = 3'd3;

	// Input transaction.
	typedef struct packed {
		logic                      req_type;
		logic [15:0]               sample_index;
		logic [HGT_W-1:0]          sample_value;
		logic signed [COORD_W-1:0] world_x;
		logic signed [COORD_W-1:0] world_y;
	} hbs_req_t;

	// Output transaction.
	typedef struct packed {
		logic [OUT_W-1:0] height_out;
		logic             in_range;
	} hbs_rsp_t;

	// Effective configuration (grid dimensions already clamped).
	typedef struct packed {
		logic [DIM_W-1:0] width;
		logic [DIM_W-1:0] height;
		logic [CFG_W-1:0] recip;
		logic [CFG_W-1:0] vscale;
	} hbs_cfg_t;

	// Item leaving the coordinate mapper: a load or a located query.
	typedef struct packed {
		logic              req_type;
		logic [15:0]       sample_index;
		logic [HGT_W-1:0]  sample_value;
		logic              in_range;
		logic [SUM_W-1:0]  base;
		logic [FRAC_W-1:0] fx;
		logic [FRAC_W-1:0] fy;
	} hbs_cell_t;

	// Query with its four corner heights, entering the interpolator.
	typedef struct packed {
		logic              in_range;
		logic [FRAC_W-1:0] fx;
		logic [FRAC_W-1:0] fy;
		logic [HGT_W-1:0]  h00;
		logic [HGT_W-1:0]  h10;
		logic [HGT_W-1:0]  h01;
		logic [HGT_W-1:0]  h11;
	} hbs_corner_t;

endpackage

FILE: hw/rtl/heightmap_bilinear_sampler.sv
`timescale 1ns / 1ps
// Heightmap bilinear sampler, top level: configuration registers and the
// mapper, memory sequencer and interpolator. Depends on hbs_pkg and submodules.
//
// Usage:
// - req channel (valid/ready): req_type 0 stores sample_value at sample_index
//   and produces no response; req_type 1 queries the height at (world_x, world_y).
// - rsp channel (valid/ready): one transaction per query, in request order,
//   with the Q16.16 height and an in-range flag (height zero when outside).
// - cfg port: write-only, one register per cycle, while the block is idle.
// Timing:
// - An in-range query reads the single-port height memory once per corner, so
//   the sequencer takes no new request until its four corner reads are issued.
//   Loads and out-of-range queries use the memory port at most once and sustain
//   one per cycle while the response side is not stalled.
// Reset clears the pipeline and loads the default configuration (256x256 grid,
// unit cell, unit gain); memory contents are undefined until loaded. When the
// receiver stalls, the pipeline fills and then drops req_ready; nothing is lost.
module heightmap_bilinear_sampler #(
	parameter int MAX_POINTS   = 65536,
	parameter int GRID_DIM_MAX = 256
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_we,
	input  logic [hbs_pkg::CIDX_W-1:0]    cfg_index,
	input  logic [hbs_pkg::CFG_W-1:0]     cfg_data,
	input  logic                          req_valid,
	output logic                          req_ready,
	input  hbs_pkg::hbs_req_t             req_item,
	output logic                          rsp_valid,
	input  logic                          rsp_ready,
	output hbs_pkg::hbs_rsp_t             rsp_item
);
	import hbs_pkg::*;

	logic [DIM_W-1:0] width_q, height_q;
	logic [CFG_W-1:0] recip_q, vscale_q;
	hbs_cfg_t         cfg;

	logic             cell_valid, cell_ready;
	hbs_cell_t        cell_item;
	logic             corner_valid, corner_ready;
	hbs_corner_t      corner;

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= DIM_W'(256);
			height_q <= DIM_W'(256);
			recip_q  <= CFG_W'(65536);
			vscale_q <= CFG_W'(256);
		end else if (cfg_we) begin
			case (cfg_index)
				REG_GRID_WIDTH:      width_q  <= cfg_data[DIM_W-1:0];
				REG_GRID_HEIGHT:     height_q <= cfg_data[DIM_W-1:0];
				REG_CELL_SIZE_RECIP: recip_q  <= cfg_data;
				REG_VERTICAL_SCALE:  vscale_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// Grid dimensions above the supported maximum are taken as the maximum.
	always_comb begin
		cfg.width  = (int'(width_q) > GRID_DIM_MAX) ? DIM_W'(GRID_DIM_MAX) : width_q;
		cfg.height = (int'(height_q) > GRID_DIM_MAX) ? DIM_W'(GRID_DIM_MAX) : height_q;
		cfg.recip  = recip_q;
		cfg.vscale = vscale_q;
	end

	hbs_coord u_coord (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg      (cfg),
		.src_valid(req_valid),
		.src_ready(req_ready),
		.src_item (req_item),
		.dst_valid(cell_valid),
		.dst_ready(cell_ready),
		.dst_item (cell_item)
	);

	hbs_seq #(
		.MAX_POINTS(MAX_POINTS)
	) u_seq (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg      (cfg),
		.src_valid(cell_valid),
		.src_ready(cell_ready),
		.src_item (cell_item),
		.dst_valid(corner_valid),
		.dst_ready(corner_ready),
		.dst_item (corner)
	);

	hbs_interp u_interp (
		.clk      (clk),
		.arst_n   (arst_n),
		.vscale   (cfg.vscale),
		.src_valid(corner_valid),
		.src_ready(corner_ready),
		.src_item (corner),
		.dst_valid(rsp_valid),
		.dst_ready(rsp_ready),
		.dst_item (rsp_item)
	);

	// A query outside the grid always reports a zero height.
	a_outside_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp_valid && !rsp_item.in_range) |-> (rsp_item.height_out == '0))
		else $error("out-of-range response with nonzero height");

endmodule

FILE: hw/rtl/hbs_ram.sv
`timescale 1ns / 1ps
// Generic single-port RAM with registered read data (read-first).
// Stand-alone; no package needed.
module hbs_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 65536
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] addr,
	input  logic [WIDTH-1:0]         wdata,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	// One access per cycle; read data appears in the cycle after the address.
	always_ff @(posedge clk) begin
		if (we) begin
			mem[addr] <= wdata;
		end
		rdata_q <= mem[addr];
	end

	assign rdata = rdata_q;

endmodule

FILE: hw/rtl/hbs_coord.sv
`timescale 1ns / 1ps
// Coordinate mapper: input register, world-to-grid multiply, cell range
// check and base address. Depends on hbs_pkg.
module hbs_coord (
	input  logic               clk,
	input  logic               arst_n,
	input  hbs_pkg::hbs_cfg_t  cfg,
	input  logic               src_valid,
	output logic               src_ready,
	input  hbs_pkg::hbs_req_t  src_item,
	output logic               dst_valid,
	input  logic               dst_ready,
	output hbs_pkg::hbs_cell_t dst_item
);
	import hbs_pkg::*;

	localparam int GP_W = COORD_W + CFG_W + 1;

	logic                   v_s1, v_s2, v_s3;
	logic                   en_s1, en_s2, en_s3;
	hbs_req_t               req_s1;
	logic                   type_s2;
	logic [15:0]            index_s2;
	logic [HGT_W-1:0]       value_s2;
	logic signed [GP_W-1:0] gx_s2, gy_s2;
	hbs_cell_t              cell_s3;

	logic [CFG_W-1:0]       x0, y0;
	logic                   x_out, y_out, rng;
	logic [2*DIM_W-1:0]     yw;
	hbs_cell_t              cell_d;

	// Stall chain: a stage loads when empty or when its content moves on.
	assign en_s3     = !v_s3 || dst_ready;
	assign en_s2     = !v_s2 || en_s3;
	assign en_s1     = !v_s1 || en_s2;
	assign src_ready = en_s1;
	assign dst_valid = v_s3;
	assign dst_item  = cell_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else begin
			if (en_s1) begin
				v_s1 <= src_valid;
			end
			if (en_s2) begin
				v_s2 <= v_s1;
			end
			if (en_s3) begin
				v_s3 <= v_s2;
			end
		end
	end

	// Grid coordinates are world times reciprocal cell size, exact signed Q24.32.
	always_ff @(posedge clk) begin
		if (en_s1) begin
			req_s1 <= src_item;
		end
		if (en_s2) begin
			type_s2  <= req_s1.req_type;
			index_s2 <= req_s1.sample_index;
			value_s2 <= req_s1.sample_value;
			gx_s2    <= req_s1.world_x * $signed({1'b0, cfg.recip});
			gy_s2    <= req_s1.world_y * $signed({1'b0, cfg.recip});
		end
		if (en_s3) begin
			cell_s3 <= cell_d;
		end
	end

	// Floor to a cell and check that the cell and its far corner lie inside.
	assign x0    = gx_s2[GP_W-2:32];
	assign y0    = gy_s2[GP_W-2:32];
	assign x_out = ({1'b0, x0} + (CFG_W+1)'(1)) >= (CFG_W+1)'(cfg.width);
	assign y_out = ({1'b0, y0} + (CFG_W+1)'(1)) >= (CFG_W+1)'(cfg.height);
	assign rng   = !gx_s2[GP_W-1] && !gy_s2[GP_W-1] && !x_out && !y_out;

	// Row-major base address; only meaningful for an in-range cell.
	assign yw = y0[DIM_W-1:0] * cfg.width;

	always_comb begin
		cell_d.req_type     = type_s2;
		cell_d.sample_index = index_s2;
		cell_d.sample_value = value_s2;
		cell_d.in_range     = rng;
		cell_d.base         = SUM_W'(yw) + SUM_W'(x0[DIM_W-1:0]);
		cell_d.fx           = gx_s2[31:16];
		cell_d.fy           = gy_s2[31:16];
	end

endmodule

FILE: hw/rtl/hbs_seq.sv
`timescale 1ns / 1ps
// Memory sequencer: owns the height memory, performs loads and the four corner
// reads of each in-range query, then hands corners on; needs hbs_pkg, hbs_ram.
module hbs_seq #(
	parameter int MAX_POINTS = 65536
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  hbs_pkg::hbs_cfg_t    cfg,
	input  logic                 src_valid,
	output logic                 src_ready,
	input  hbs_pkg::hbs_cell_t   src_item,
	output logic                 dst_valid,
	input  logic                 dst_ready,
	output hbs_pkg::hbs_corner_t dst_item
);
	import hbs_pkg::*;

	localparam int ADDR_W = $clog2(MAX_POINTS);

	// Corner read order.
	localparam logic [1:0] BEAT_H00 = 2'd0;
	localparam logic [1:0] BEAT_H10 = 2'd1;
	localparam logic [1:0] BEAT_H01 = 2'd2;
	localparam logic [1:0] BEAT_H11 = 2'd3;

	logic              v_s4, v_s5;
	logic              en_s4, en_s5;
	hbs_cell_t         cell_s4;
	logic [HGT_W-1:0]  h00_s4, h10_s4, h01_s4;
	hbs_corner_t       corner_s5;
	logic [HGT_W-1:0]  h11_s5;
	logic [1:0]        cnt_q;
	logic              cap_q;
	logic              fresh_q;

	logic              m_query, m_rd, m_done, offer, leave;
	logic              load_ok;
	logic [SUM_W-1:0]  off;
	logic              ram_we;
	logic [ADDR_W-1:0] ram_addr;
	logic [HGT_W-1:0]  rdata;
	logic [HGT_W-1:0]  h01_now;
	hbs_corner_t       corner_d;

	hbs_ram #(
		.WIDTH(HGT_W),
		.DEPTH(MAX_POINTS)
	) u_ram (
		.clk  (clk),
		.we   (ram_we),
		.addr (ram_addr),
		.wdata(cell_s4.sample_value),
		.rdata(rdata)
	);

	// Loads leave with their write; queries on their last read, or unread if outside.
	assign m_query = v_s4 && (cell_s4.req_type == REQ_QUERY);
	assign m_rd    = m_query && cell_s4.in_range;
	assign m_done  = !cell_s4.in_range || (cnt_q == BEAT_H11);
	assign offer   = m_query && m_done;
	assign leave   = v_s4 && ((cell_s4.req_type == REQ_LOAD) || (m_done && en_s5));
	assign en_s5   = !v_s5 || dst_ready;
	assign en_s4   = !v_s4 || leave;
	assign src_ready = en_s4;

	// Loads beyond the memory are dropped.
	assign load_ok = int'(cell_s4.sample_index) < MAX_POINTS;
	assign ram_we  = v_s4 && (cell_s4.req_type == REQ_LOAD) && load_ok;

	// Corner offset from the base for the current read beat.
	always_comb begin
		unique case (cnt_q)
			BEAT_H00: off = '0;
			BEAT_H10: off = SUM_W'(1);
			BEAT_H01: off = SUM_W'(cfg.width);
			BEAT_H11: off = SUM_W'(cfg.width) + SUM_W'(1);
		endcase
	end

	// Addresses wrap at the memory size.
	always_comb begin
		if (cell_s4.req_type == REQ_LOAD) begin
			ram_addr = ADDR_W'(cell_s4.sample_index);
		end else begin
			ram_addr = ADDR_W'(cell_s4.base + off);
		end
	end

	// Stage valids and read beat counter.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s4    <= 1'b0;
			v_s5    <= 1'b0;
			cnt_q   <= BEAT_H00;
			cap_q   <= 1'b0;
			fresh_q <= 1'b0;
		end else begin
			if (en_s4) begin
				v_s4  <= src_valid;
				cnt_q <= BEAT_H00;
				cap_q <= 1'b0;
			end else if (m_rd) begin
				if (cnt_q != BEAT_H11) begin
					cnt_q <= cnt_q + 2'd1;
					cap_q <= 1'b1;
				end else begin
					cap_q <= 1'b0;
				end
			end
			if (en_s5) begin
				v_s5    <= offer;
				fresh_q <= offer && cell_s4.in_range;
			end else begin
				fresh_q <= 1'b0;
			end
		end
	end

	// The third corner may still be on the read port when the query leaves.
	assign h01_now = (cap_q && (cnt_q == BEAT_H11)) ? rdata : h01_s4;

	always_comb begin
		corner_d.in_range = cell_s4.in_range;
		corner_d.fx       = cell_s4.fx;
		corner_d.fy       = cell_s4.fy;
		corner_d.h00      = h00_s4;
		corner_d.h10      = h10_s4;
		corner_d.h01      = h01_now;
		corner_d.h11      = '0;
	end

	// Capture each corner the cycle after its read was issued.
	always_ff @(posedge clk) begin
		if (en_s4) begin
			cell_s4 <= src_item;
		end
		if (cap_q) begin
			case (cnt_q)
				BEAT_H10: h00_s4 <= rdata;
				BEAT_H01: h10_s4 <= rdata;
				BEAT_H11: h01_s4 <= rdata;
				default: ;
			endcase
		end
		if (en_s5) begin
			corner_s5 <= corner_d;
		end
		if (fresh_q) begin
			h11_s5 <= rdata;
		end
	end

	// The last corner arrives in the first cycle after the hand-over.
	always_comb begin
		dst_item     = corner_s5;
		dst_item.h11 = fresh_q ? rdata : h11_s5;
	end
	assign dst_valid = v_s5;

	// A pending capture always belongs to a query still held in the read stage.
	a_cap_held: assert property (@(posedge clk) disable iff (!arst_n)
		cap_q |-> (v_s4 && (cnt_q != BEAT_H00)))
		else $error("corner capture without a query in the read stage");

	// A load never writes while a query's corner reads are under way.
	a_no_write_mid_query: assert property (@(posedge clk) disable iff (!arst_n)
		ram_we |-> ((cnt_q == BEAT_H00) && !cap_q))
		else $error("memory write during a corner read sequence");

	// The last corner is only awaited for an in-range query that just moved on.
	a_fresh_query: assert property (@(posedge clk) disable iff (!arst_n)
		fresh_q |-> (v_s5 && corner_s5.in_range && $past(m_rd && (cnt_q == BEAT_H11))))
		else $error("last corner pending without a matching query");

endmodule

FILE: hw/rtl/hbs_interp.sv
`timescale 1ns / 1ps
// Bilinear interpolator: weights the four corners, rounds to Q0.24,
// applies the vertical gain and rounds to Q16.16. Depends on hbs_pkg.
module hbs_interp (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic [hbs_pkg::CFG_W-1:0] vscale,
	input  logic                 src_valid,
	output logic                 src_ready,
	input  hbs_pkg::hbs_corner_t src_item,
	output logic                 dst_valid,
	input  logic                 dst_ready,
	output hbs_pkg::hbs_rsp_t    dst_item
);
	import hbs_pkg::*;

	localparam int P_W = 2 * FRAC_W;
	localparam int Q_W = 3 * FRAC_W;

	logic              v_s6, v_s7, v_s8, v_s9, v_s10, v_s11;
	logic              en_s6, en_s7, en_s8, en_s9, en_s10, en_s11;
	logic [P_W-1:0]    p00_s6, p10_s6, p01_s6, p11_s6;
	logic [FRAC_W-1:0] fy_s6, fy_s7;
	logic [P_W-1:0]    h0_s7, h1_s7;
	logic [Q_W-1:0]    q0_s8, q1_s8;
	logic [CFG_W-1:0]  hq_s9;
	logic [Q_W-1:0]    prod_s10;
	hbs_rsp_t          rsp_s11;
	logic              rng_s6, rng_s7, rng_s8, rng_s9, rng_s10;

	logic [FRAC_W:0]   wx0, wy0;
	logic [Q_W:0]      hsum, rsum;
	logic [OUT_W-1:0]  res;

	// Stall chain from the output register backwards.
	assign en_s11 = !v_s11 || dst_ready;
	assign en_s10 = !v_s10 || en_s11;
	assign en_s9  = !v_s9  || en_s10;
	assign en_s8  = !v_s8  || en_s9;
	assign en_s7  = !v_s7  || en_s8;
	assign en_s6  = !v_s6  || en_s7;
	assign src_ready = en_s6;
	assign dst_valid = v_s11;
	assign dst_item  = rsp_s11;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s6  <= 1'b0;
			v_s7  <= 1'b0;
			v_s8  <= 1'b0;
			v_s9  <= 1'b0;
			v_s10 <= 1'b0;
			v_s11 <= 1'b0;
		end else begin
			if (en_s6) v_s6 <= src_valid;
			if (en_s7) v_s7 <= v_s6;
			if (en_s8) v_s8 <= v_s7;
			if (en_s9) v_s9 <= v_s8;
			if (en_s10) v_s10 <= v_s9;
			if (en_s11) v_s11 <= v_s10;
		end
	end

	// Complementary weights 1.0 - f in Q0.16, one bit wider.
	assign wx0 = (FRAC_W+1)'(1 << FRAC_W) - (FRAC_W+1)'(src_item.fx);
	assign wy0 = (FRAC_W+1)'(1 << FRAC_W) - (FRAC_W+1)'(fy_s7);

	// Round the Q0.48 height half up to Q0.24.
	assign hsum = (Q_W+1)'(q0_s8) + (Q_W+1)'(q1_s8) + ((Q_W+1)'(1) << 23);
	// Round the Q16.32 product half up to Q16.16, saturating on overflow.
	assign rsum = (Q_W+1)'(prod_s10) + ((Q_W+1)'(1) << 15);
	assign res  = (rsum[Q_W:OUT_W+16] != '0) ? '1 : rsum[OUT_W+15:16];

	always_ff @(posedge clk) begin
		// Horizontal weighting of each corner.
		if (en_s6) begin
			p00_s6 <= P_W'(src_item.h00 * wx0);
			p10_s6 <= P_W'(src_item.h10 * src_item.fx);
			p01_s6 <= P_W'(src_item.h01 * wx0);
			p11_s6 <= P_W'(src_item.h11 * src_item.fx);
			fy_s6  <= src_item.fy;
			rng_s6 <= src_item.in_range;
		end
		// Row sums, exact Q0.32.
		if (en_s7) begin
			h0_s7  <= p00_s6 + p10_s6;
			h1_s7  <= p01_s6 + p11_s6;
			fy_s7  <= fy_s6;
			rng_s7 <= rng_s6;
		end
		// Vertical weighting.
		if (en_s8) begin
			q0_s8  <= Q_W'(h0_s7 * wy0);
			q1_s8  <= Q_W'(h1_s7 * fy_s7);
			rng_s8 <= rng_s7;
		end
		if (en_s9) begin
			hq_s9  <= hsum[CFG_W+23:24];
			rng_s9 <= rng_s8;
		end
		// Vertical gain, Q0.24 times Q16.8.
		if (en_s10) begin
			prod_s10 <= Q_W'(hq_s9 * vscale);
			rng_s10  <= rng_s9;
		end
		// Out-of-range queries report zero.
		if (en_s11) begin
			rsp_s11.height_out <= rng_s10 ? res : '0;
			rsp_s11.in_range   <= rng_s10;
		end
	end

endmodule

FILE: test/hbs_height_checker.sv
`timescale 1ns / 1ps
// Scoreboard for the heightmap bilinear sampler: keeps its own configuration and
// height store, predicts each query's height and compares the responses.
// Depends on hbs_pkg.
module hbs_height_checker
	import hbs_pkg::*;
(
	input  logic                clk,
	input  logic                arst_n,
	input  logic                cfg_we,
	input  logic [CIDX_W-1:0]   cfg_index,
	input  logic [CFG_W-1:0]    cfg_data,
	input  logic                req_valid,
	input  logic                req_ready,
	input  hbs_req_t            req_item,
	input  logic                rsp_valid,
	input  logic                rsp_ready,
	input  hbs_rsp_t            rsp_item,
	output int                  failures,
	output int                  pending
);

	localparam int GRID_LIMIT = 256;

	// Shadow configuration and height store.
	logic [DIM_W-1:0] grid_w;
	logic [DIM_W-1:0] grid_h;
	logic [CFG_W-1:0] recip;
	logic [CFG_W-1:0] vscale;
	logic [HGT_W-1:0] heights [0:65535];

	// Responses still owed by the block, oldest first.
	hbs_rsp_t expected_heights [$];
	hbs_rsp_t want;

	initial begin
		failures = 0;
		pending = 0;
	end

	// Height the block should return for one query transaction.
	function automatic hbs_rsp_t interpolate_height(input hbs_req_t r);
		longint gx, gy;
		logic [63:0] ux, uy, fx, fy;
		logic [63:0] c00, c10, c01, c11, top, bot, mix, hq, prod;
		logic [31:0] base;
		logic [15:0] a00, a10, a01, a11;
		int w, h;
		hbs_rsp_t res;
		w = (grid_w > GRID_LIMIT) ? GRID_LIMIT : int'(grid_w);
		h = (grid_h > GRID_LIMIT) ? GRID_LIMIT : int'(grid_h);
		res = '0;
		gx = $signed(r.world_x) * $signed({40'd0, recip});
		gy = $signed(r.world_y) * $signed({40'd0, recip});
		// Negative positions and cells touching the last row or column are outside.
		if (gx < 0 || gy < 0)
			return res;
		if ((gx >>> 32) + 1 >= w || (gy >>> 32) + 1 >= h)
			return res;
		ux = gx;
		uy = gy;
		fx = {48'd0, ux[31:16]};
		fy = {48'd0, uy[31:16]};
		// Corner addresses wrap at the store size.
		base = 32'(uy[63:32] * w + ux[63:32]);
		a00 = base[15:0];
		a10 = 16'(base + 1);
		a01 = 16'(base + w);
		a11 = 16'(base + w + 1);
		c00 = {48'd0, heights[a00]};
		c10 = {48'd0, heights[a10]};
		c01 = {48'd0, heights[a01]};
		c11 = {48'd0, heights[a11]};
		top = c00 * (64'd65536 - fx) + c10 * fx;
		bot = c01 * (64'd65536 - fx) + c11 * fx;
		mix = top * (64'd65536 - fy) + bot * fy;
		// Round half up to Q0.24, apply the gain, round half up to Q16.16.
		hq = (mix + (64'd1 << 23)) >> 24;
		prod = hq * {40'd0, vscale};
		prod = (prod + (64'd1 << 15)) >> 16;
		res.height_out = (prod > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : prod[31:0];
		res.in_range = 1'b1;
		return res;
	endfunction

	// Track configuration writes, predict accepted requests and check responses.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			grid_w = 9'd256;
			grid_h = 9'd256;
			recip = 24'd65536;
			vscale = 24'd256;
			expected_heights.delete();
			pending <= 0;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					REG_GRID_WIDTH: grid_w = cfg_data[DIM_W-1:0];
					REG_GRID_HEIGHT: grid_h = cfg_data[DIM_W-1:0];
					REG_CELL_SIZE_RECIP: recip = cfg_data;
					REG_VERTICAL_SCALE: vscale = cfg_data;
					default: ;
				endcase
			end
			if (rsp_valid && rsp_ready) begin
				if (expected_heights.size() == 0) begin
					$error("unexpected response transaction: height_out %0h in_range %0b",
						rsp_item.height_out, rsp_item.in_range);
					failures++;
				end else begin
					want = expected_heights.pop_front();
					if (rsp_item.height_out !== want.height_out) begin
						$error("height_out: expected %0h, got %0h",
							want.height_out, rsp_item.height_out);
						failures++;
					end
					if (rsp_item.in_range !== want.in_range) begin
						$error("in_range: expected %0b, got %0b",
							want.in_range, rsp_item.in_range);
						failures++;
					end
				end
			end
			if (req_valid && req_ready) begin
				if (req_item.req_type == REQ_LOAD)
					heights[req_item.sample_index] = req_item.sample_value;
				else
					expected_heights.push_back(interpolate_height(req_item));
			end
			pending <= expected_heights.size();
		end
	end

endmodule

FILE: test/testbench.sv
`timescale 1ns / 1ps
// Top of the heightmap bilinear sampler testbench: clock, reset, configuration
// phases, load and query stimulus and the verdict. Depends on hbs_pkg, the block
// and hbs_height_checker.
module testbench;
	import hbs_pkg::*;

	localparam int CLK_HALF = 4;
	localparam int GRID_LIMIT = 256;
	localparam int DRAIN_CYCLES = 32;
	localparam int RANDOM_ITEMS = 300;
	localparam longint CYCLE_LIMIT = 64'd4_000_000;
	// First index past the defined registers.
	localparam logic [CIDX_W-1:0] REG_SPARE = 3'd4;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_we = 1'b0;
	logic [CIDX_W-1:0] cfg_index = '0;
	logic [CFG_W-1:0] cfg_data = '0;
	logic req_valid = 1'b0;
	logic req_ready;
	hbs_req_t req_item = '0;
	logic rsp_valid;
	logic rsp_ready = 1'b0;
	hbs_rsp_t rsp_item;
	int failures;
	int pending;

	// Current configuration as the stimulus sees it.
	logic [DIM_W-1:0] cur_w = 9'd256;
	logic [DIM_W-1:0] cur_h = 9'd256;
	logic [CFG_W-1:0] cur_recip = 24'd65536;
	int eff_w = GRID_LIMIT;
	int eff_h = GRID_LIMIT;

	// Store entries loaded so far; queries never touch any other entry.
	bit written [0:65535];

	int tx_calm = 0;
	int rx_stall = 0;
	int rx_calm = 0;
	longint cycle_count = 0;

	always begin
		#CLK_HALF clk = 1'b1;
		#CLK_HALF clk = 1'b0;
	end

	heightmap_bilinear_sampler dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.req_valid (req_valid),
		.req_ready (req_ready),
		.req_item  (req_item),
		.rsp_valid (rsp_valid),
		.rsp_ready (rsp_ready),
		.rsp_item  (rsp_item)
	);

	hbs_height_checker height_check (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.req_valid (req_valid),
		.req_ready (req_ready),
		.req_item  (req_item),
		.rsp_valid (rsp_valid),
		.rsp_ready (rsp_ready),
		.rsp_item  (rsp_item),
		.failures  (failures),
		.pending   (pending)
	);

	// Response side: short and long stalls, with calm stretches of steady ready.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_ready <= 1'b0;
			rx_stall <= 0;
			rx_calm <= 0;
		end else if (rx_stall > 0) begin
			rx_stall <= rx_stall - 1;
			rsp_ready <= 1'b0;
		end else if (rx_calm > 0) begin
			rx_calm <= rx_calm - 1;
			rsp_ready <= 1'b1;
		end else begin
			case ($urandom_range(0, 99)) inside
				[0:4]: begin
					rx_calm <= $urandom_range(20, 150);
					rsp_ready <= 1'b1;
				end
				[5:24]: begin
					rx_stall <= $urandom_range(0, 2);
					rsp_ready <= 1'b0;
				end
				[25:27]: begin
					rx_stall <= $urandom_range(10, 40);
					rsp_ready <= 1'b0;
				end
				default: rsp_ready <= 1'b1;
			endcase
		end
	end

	// Watchdog on the whole run.
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("Test completed with failures");
			$finish;
		end
	end

	// Offer one request transaction after a random idle gap and wait for acceptance.
	task automatic push_req(input hbs_req_t r);
		int gap;
		int roll;
		gap = 0;
		if (tx_calm > 0) begin
			tx_calm--;
		end else begin
			roll = $urandom_range(0, 99);
			if (roll < 3)
				tx_calm = $urandom_range(20, 120);
			else if (roll < 55)
				gap = 0;
			else if (roll < 95)
				gap = $urandom_range(1, 3);
			else
				gap = $urandom_range(8, 40);
		end
		if (gap > 0) begin
			req_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		req_valid <= 1'b1;
		req_item <= r;
		do @(posedge clk); while (!req_ready);
	endtask

	task automatic load_sample(input int idx, input logic [HGT_W-1:0] value);
		hbs_req_t r;
		r.req_type = REQ_LOAD;
		r.sample_index = idx[15:0];
		r.sample_value = value;
		r.world_x = $urandom;
		r.world_y = $urandom;
		push_req(r);
		written[idx[15:0]] = 1'b1;
	endtask

	// Cell that a query falls in, as the stimulus needs it to preload corners.
	function automatic bit locate_cell(input logic [31:0] wx, input logic [31:0] wy,
			output int base);
		longint gx, gy;
		base = 0;
		gx = $signed(wx) * $signed({40'd0, cur_recip});
		gy = $signed(wy) * $signed({40'd0, cur_recip});
		if (gx < 0 || gy < 0)
			return 1'b0;
		if ((gx >>> 32) + 1 >= eff_w || (gy >>> 32) + 1 >= eff_h)
			return 1'b0;
		base = int'(gy >>> 32) * eff_w + int'(gx >>> 32);
		return 1'b1;
	endfunction

	// Query a position, first loading any of its four corners not yet written.
	task automatic send_query(input logic [31:0] wx, input logic [31:0] wy);
		hbs_req_t r;
		int base;
		int corner [4];
		if (locate_cell(wx, wy, base)) begin
			corner[0] = base;
			corner[1] = base + 1;
			corner[2] = base + eff_w;
			corner[3] = base + eff_w + 1;
			foreach (corner[k])
				if (!written[corner[k][15:0]])
					load_sample(corner[k] & 16'hFFFF, HGT_W'($urandom));
		end
		r.req_type = REQ_QUERY;
		r.sample_index = 16'($urandom);
		r.sample_value = HGT_W'($urandom);
		r.world_x = wx;
		r.world_y = wy;
		push_req(r);
	endtask

	task automatic write_reg(input logic [CIDX_W-1:0] idx, input logic [CFG_W-1:0] data);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		@(posedge clk);
	endtask

	// Write every register, with junk above the dimension fields and a spare index.
	task automatic set_config(input int w, input int h, input int recip, input int vs);
		write_reg(REG_GRID_WIDTH, {15'($urandom), 9'(w)});
		write_reg(REG_SPARE + 3'($urandom_range(0, 3)), CFG_W'($urandom));
		write_reg(REG_GRID_HEIGHT, {15'($urandom), 9'(h)});
		write_reg(REG_CELL_SIZE_RECIP, 24'(recip));
		write_reg(REG_VERTICAL_SCALE, 24'(vs));
		cfg_we <= 1'b0;
		cur_w = 9'(w);
		cur_h = 9'(h);
		cur_recip = 24'(recip);
		eff_w = (cur_w > GRID_LIMIT) ? GRID_LIMIT : int'(cur_w);
		eff_h = (cur_h > GRID_LIMIT) ? GRID_LIMIT : int'(cur_h);
	endtask

	// Block is idle: no response owed and any load has left the pipeline.
	task automatic wait_idle();
		req_valid <= 1'b0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	// World coordinate that mostly lands inside a grid dimension.
	function automatic logic [31:0] aim_coord(input int dim);
		longint lim;
		if (cur_recip == 0)
			return $urandom;
		lim = (longint'(dim) <<< 32) / longint'(cur_recip);
		if (lim > 64'sh7FFF_FFFF)
			lim = 64'sh7FFF_FFFF;
		return $urandom_range(0, 32'(lim));
	endfunction

	// Random mix of loads and queries, most queries aimed at the grid.
	task automatic run_random(input int count);
		int roll;
		int idx;
		int sel;
		logic [31:0] wx, wy;
		for (int n = 0; n < count; n++) begin
			roll = $urandom_range(0, 99);
			if (roll < 22) begin
				if (eff_w * eff_h > 0 && $urandom_range(0, 1))
					idx = $urandom_range(0, eff_w * eff_h - 1);
				else
					idx = $urandom_range(0, 65535);
				load_sample(idx, HGT_W'($urandom));
			end else begin
				wx = aim_coord(eff_w);
				wy = aim_coord(eff_h);
				if (roll < 30) begin
					wx = $urandom;
					wy = $urandom;
				end else if (roll < 42) begin
					sel = $urandom_range(1, 3);
					if (sel[0])
						wx[31] = 1'b1;
					if (sel[1])
						wy[31] = 1'b1;
				end
				send_query(wx, wy);
			end
		end
	endtask

	initial begin
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Full 256x256 grid, unit cell and unit gain.
		set_config(256, 256, 65536, 256);
		load_sample(0, 16'hFFFF);
		load_sample(1, 16'h0000);
		load_sample(256, 16'h8000);
		load_sample(257, 16'hFFFF);
		send_query(32'h0000_0000, 32'h0000_0000);
		send_query(32'h0000_FFFF, 32'h0000_FFFF);
		send_query(32'h0000_8000, 32'h0000_8000);
		load_sample(65278, 16'h0000);
		load_sample(65279, 16'hFFFF);
		load_sample(65534, 16'hFFFF);
		load_sample(65535, 16'hFFFF);
		// Last full cell, then the last column and the last row.
		send_query(32'h00FE_FFFF, 32'h00FE_FFFF);
		send_query(32'h00FF_0000, 32'h0000_0000);
		send_query(32'h0000_0000, 32'h00FF_0000);
		// Negative and extreme coordinates.
		send_query(32'hFFFF_FFFF, 32'h0000_0000);
		send_query(32'h8000_0000, 32'h8000_0000);
		send_query(32'h7FFF_FFFF, 32'h7FFF_FFFF);
		run_random(150);

		// Smallest grid with the largest reciprocal and gain.
		wait_idle();
		set_config(2, 2, 24'hFFFFFF, 24'hFFFFFF);
		load_sample(0, 16'hFFFF);
		load_sample(1, 16'hFFFF);
		load_sample(2, 16'hFFFF);
		load_sample(3, 16'hFFFF);
		send_query(32'h0000_00FF, 32'h0000_00FF);
		send_query(32'h0000_0000, 32'h0000_0000);
		send_query(32'h0000_0101, 32'h0000_0000);
		run_random(120);

		// Width above the grid limit, zero gain.
		wait_idle();
		set_config(511, 3, 24'hFFFFFF, 0);
		run_random(120);

		// Zero reciprocal maps every position to the first cell.
		wait_idle();
		set_config(5, 4, 0, 256);
		run_random(100);

		// Grids too small to hold a cell.
		wait_idle();
		set_config(1, 7, 65536, 256);
		run_random(60);
		wait_idle();
		set_config(300, 0, 1 << 20, 256);
		run_random(60);

		// Random settings, mostly small grids.
		for (int p = 0; p < 5; p++) begin
			wait_idle();
			set_config(($urandom_range(0, 3) == 0) ? $urandom_range(0, 511) : $urandom_range(2, 40),
				($urandom_range(0, 3) == 0) ? $urandom_range(0, 511) : $urandom_range(2, 40),
				$urandom_range(0, 1) ? $urandom_range(1 << 12, 1 << 18) : $urandom_range(0, 24'hFFFFFF),
				$urandom_range(0, 24'hFFFFFF));
			run_random(RANDOM_ITEMS);
		end

		wait_idle();
		if (failures == 0 && pending == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end

endmodule

FILE: files.f
hw/rtl/hbs_pkg.sv
hw/rtl/hbs_ram.sv
hw/rtl/hbs_coord.sv
hw/rtl/hbs_seq.sv
hw/rtl/hbs_interp.sv
hw/rtl/heightmap_bilinear_sampler.sv
test/hbs_height_checker.sv
test/testbench.sv
